FILE: rtl/mc_pkg.sv
// Shared types, constants and edge tables for the marching-cubes cell.
// Used by the channel interfaces, the divider, the top level and the checker.
package mc_pkg;

	localparam int CORNER_COUNT  = 8;
	localparam int ROW_WORDS     = 15;
	localparam int TABLE_DEPTH   = 256 * ROW_WORDS;
	localparam int TBL_AW        = 12;
	localparam int EDGE_COUNT    = 12;
	localparam int EP_DEPTH      = 3 * EDGE_COUNT;
	localparam int EP_AW         = 6;
	localparam int POS_DEPTH     = 3 * CORNER_COUNT;
	localparam int POS_AW        = 5;
	localparam int CFG_IDX_W     = 1;
	localparam int MAX_TRIS_DEF  = 5;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [3:0] NO_TRI    = 4'd15;
	localparam logic [7:0] CASE_MAX  = 8'd255;

	typedef enum logic [1:0] {
		OP_CORNER  = 2'd0,
		OP_TABLE   = 2'd1,
		OP_AMBIG   = 2'd2,
		OP_COMPUTE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ISO     = 1'b0,
		REG_RESOLVE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic        [1:0]  opcode;
		logic        [2:0]  corner_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] corner_weight;
		logic        [11:0] table_address;
		logic        [3:0]  table_word;
		logic        [7:0]  case_select;
		logic               ambiguous_bit;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic               has_triangle;
		logic               last_triangle;
	} out_item_t;

	// first and second corner of each cube edge
	function automatic logic [2:0] edge_c1(input logic [3:0] e);
		logic [2:0] c;
		case (e)
			4'd0, 4'd8:  c = 3'd0;
			4'd1, 4'd9:  c = 3'd1;
			4'd2, 4'd11: c = 3'd2;
			4'd3, 4'd10: c = 3'd3;
			4'd4:        c = 3'd4;
			4'd5:        c = 3'd5;
			4'd6:        c = 3'd6;
			4'd7:        c = 3'd7;
			default:     c = 3'd0;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] edge_c2(input logic [3:0] e);
		logic [2:0] c;
		case (e)
			4'd0:        c = 3'd1;
			4'd1:        c = 3'd2;
			4'd2:        c = 3'd3;
			4'd3:        c = 3'd0;
			4'd4, 4'd9:  c = 3'd5;
			4'd5, 4'd11: c = 3'd6;
			4'd6, 4'd10: c = 3'd7;
			4'd7, 4'd8:  c = 3'd4;
			default:     c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/mc_if.sv
// Valid/ready channel interfaces for the marching-cubes cell.
// Depends on mc_pkg for the payload types.
interface mc_in_if import mc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mc_out_if import mc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mc_cfg_if import mc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          value;
	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

FILE: rtl/marching_cubes_cell_top.sv
// Marching-cubes cell: corner, table and ambiguity stores, edge interpolation, emit.
// Compute time is set by the shared bit-serial divider, used once per crossing edge,
// by single-port reads and by output stalls. Load items are taken while the cell is idle;
// a compute holds off new items until it is done. Reset clears control, configuration and
// the ambiguity mask; corner, table and edge stores are undefined until written.
module marching_cubes_cell_top import mc_pkg::*; #(
	parameter int MAX_TRIS  = MAX_TRIS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	mc_in_if.sink    item,
	mc_out_if.source result,
	mc_cfg_if.sink   cfg
);
	localparam int T_W    = FRAC_BITS + 1;
	localparam int PROD_W = 33 + T_W + 1;
	localparam int SLOT_W = $clog2(MAX_TRIS + 1);

	typedef enum logic [18:0] {
		S_IDLE     = 19'h00001,
		S_CASE     = 19'h00002,
		S_ROW      = 19'h00004,
		S_W1       = 19'h00008,
		S_W2       = 19'h00010,
		S_ABS      = 19'h00020,
		S_CHK      = 19'h00040,
		S_DIV      = 19'h00080,
		S_P1       = 19'h00100,
		S_P2       = 19'h00200,
		S_MUL      = 19'h00400,
		S_WR       = 19'h00800,
		S_SCAN_RD  = 19'h01000,
		S_SCAN_CAP = 19'h02000,
		S_NEXT     = 19'h04000,
		S_TW_RD    = 19'h08000,
		S_TW_CAP   = 19'h10000,
		S_PT       = 19'h20000,
		S_EMIT     = 19'h40000
	} state_t;

	state_t state_q;

	// configuration and ambiguity mask
	logic signed [31:0] iso_q;
	logic               resolve_q;
	logic [255:0]       ambig_q;

	// corner stores
	logic [31:0] pos_q [POS_DEPTH];
	logic [31:0] cv_q [CORNER_COUNT];

	// memories
	logic [3:0]  tt_mem [TABLE_DEPTH];
	logic [3:0]  tt_rd_q;
	logic [31:0] ep_mem [EP_DEPTH];
	logic [31:0] ep_rd_q;

	// sequencer counters
	logic [3:0]          edge_q;
	logic [1:0]          ax_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [1:0]          j_q;
	logic [1:0]          v_q;
	logic                pt_phase_q;
	logic [MAX_TRIS-1:0] found_q;
	logic                valid_q;
	logic                out_valid_q;

	// datapath registers
	logic [7:0]               case_q;
	logic [TBL_AW-1:0]        base_q;
	logic [31:0]              w1_q;
	logic [32:0]              num_q;
	logic [32:0]              den_q;
	logic [T_W-1:0]           t_q;
	logic [31:0]              p1_q;
	logic signed [32:0]       diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [3:0]               code_q [3];
	logic [31:0]              pt_q [9];
	out_item_t                out_q;

	logic [2:0]        c1, c2;
	logic [7:0]        cs;
	logic [7:0]        row;
	logic              edge_ok;
	logic              div_start;
	logic              div_busy;
	logic [T_W-1:0]    div_quot;
	logic [POS_AW-1:0] pa1, pa2;
	logic [EP_AW-1:0]  ep_wa, ep_ra;
	logic              ep_we;
	logic [31:0]       ep_wd;
	logic [TBL_AW-1:0] tt_ra;
	logic              tt_we;
	logic              out_free;
	logic              out_load;
	logic              more_tris;
	logic [3:0]        cur_code;
	logic [3:0]        pt_idx;
	logic              item_xfer;
	logic              cfg_xfer;

	assign item_xfer = item.valid && item.ready;
	assign cfg_xfer  = cfg.valid && cfg.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign out_free   = !out_valid_q || result.ready;
	assign out_load   = out_free &&
		(((state_q == S_NEXT) && (found_q == '0)) || (state_q == S_EMIT));

	assign c1  = edge_c1(edge_q);
	assign c2  = edge_c2(edge_q);
	assign pa1 = POS_AW'(c1) * POS_AW'(3) + POS_AW'(ax_q);
	assign pa2 = POS_AW'(c2) * POS_AW'(3) + POS_AW'(ax_q);

	always_comb begin
		cs = '0;
		for (int i = 0; i < CORNER_COUNT; i++)
			cs[i] = $signed(cv_q[i]) > iso_q;
	end

	assign row = (ambig_q[case_q] && !resolve_q) ? (CASE_MAX - case_q) : case_q;

	assign edge_ok = (den_q != 33'd0) && !num_q[32] && (num_q[31:0] <= den_q[31:0]);
	assign div_start = (state_q == S_CHK) && edge_ok;

	mc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[31:0]),
		.den    (den_q[31:0]),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// edge point store: written per axis, read per axis of each triangle vertex
	assign ep_we    = (state_q == S_WR);
	assign ep_wa    = EP_AW'(edge_q) * EP_AW'(3) + EP_AW'(ax_q);
	assign ep_wd    = valid_q ? (p1_q + 32'(prod_q[FRAC_BITS+31:FRAC_BITS])) : 32'd0;
	assign cur_code = code_q[v_q];
	assign ep_ra    = (cur_code < 4'(EDGE_COUNT)) ?
		(EP_AW'(cur_code) * EP_AW'(3) + EP_AW'(ax_q)) : '0;
	assign pt_idx   = 4'(v_q) * 4'd3 + 4'(ax_q);

	always_ff @(posedge clk) begin
		if (ep_we)
			ep_mem[ep_wa] <= ep_wd;
		ep_rd_q <= ep_mem[ep_ra];
	end

	// triangle table
	assign tt_we = item_xfer && (item.data.opcode == OP_TABLE) &&
		(item.data.table_address < TBL_AW'(TABLE_DEPTH));
	assign tt_ra = base_q + TBL_AW'(slot_q) * TBL_AW'(3) + TBL_AW'(j_q);

	always_ff @(posedge clk) begin
		if (tt_we)
			tt_mem[item.data.table_address] <= item.data.table_word;
		tt_rd_q <= tt_mem[tt_ra];
	end

	// any found triangle beyond the current slot
	always_comb begin
		more_tris = 1'b0;
		for (int i = 0; i < MAX_TRIS; i++)
			if (SLOT_W'(i) > slot_q)
				more_tris = more_tris | found_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iso_q       <= '0;
			resolve_q   <= 1'b0;
			ambig_q     <= '0;
			edge_q      <= '0;
			ax_q        <= '0;
			slot_q      <= '0;
			j_q         <= '0;
			v_q         <= '0;
			pt_phase_q  <= 1'b0;
			found_q     <= '0;
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				unique case (cfg.index)
					REG_ISO:     iso_q <= cfg.value;
					REG_RESOLVE: resolve_q <= cfg.value[0];
					default:     ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						if (item.data.opcode == OP_AMBIG)
							ambig_q[item.data.case_select] <= item.data.ambiguous_bit;
						if (item.data.opcode == OP_COMPUTE)
							state_q <= S_CASE;
					end
				end
				S_CASE: state_q <= S_ROW;
				S_ROW: begin
					edge_q  <= '0;
					state_q <= S_W1;
				end
				S_W1:  state_q <= S_W2;
				S_W2:  state_q <= S_ABS;
				S_ABS: state_q <= S_CHK;
				S_CHK: begin
					ax_q    <= '0;
					valid_q <= edge_ok;
					state_q <= edge_ok ? S_DIV : S_P1;
				end
				S_DIV: begin
					if (!div_busy)
						state_q <= S_P1;
				end
				S_P1:  state_q <= S_P2;
				S_P2:  state_q <= S_MUL;
				S_MUL: state_q <= S_WR;
				S_WR: begin
					if (ax_q != 2'd2) begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_P1;
					end else if (edge_q != 4'(EDGE_COUNT - 1)) begin
						edge_q  <= edge_q + 1'b1;
						state_q <= S_W1;
					end else begin
						slot_q  <= '0;
						j_q     <= '0;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CAP;
				S_SCAN_CAP: begin
					found_q[slot_q] <= (tt_rd_q != NO_TRI);
					if (slot_q != SLOT_W'(MAX_TRIS - 1)) begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						slot_q  <= '0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (found_q == '0) begin
						// no triangle: a single empty final result
						if (out_free)
							state_q <= S_IDLE;
					end else if (slot_q == SLOT_W'(MAX_TRIS)) begin
						state_q <= S_IDLE;
					end else if (found_q[slot_q]) begin
						j_q     <= '0;
						state_q <= S_TW_RD;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_TW_RD: state_q <= S_TW_CAP;
				S_TW_CAP: begin
					if (j_q != 2'd2) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_TW_RD;
					end else begin
						v_q        <= '0;
						ax_q       <= '0;
						pt_phase_q <= 1'b0;
						state_q    <= S_PT;
					end
				end
				S_PT: begin
					// read issue then capture, per vertex coordinate
					pt_phase_q <= !pt_phase_q;
					if (pt_phase_q) begin
						if (ax_q != 2'd2) begin
							ax_q <= ax_q + 1'b1;
						end else begin
							ax_q <= '0;
							if (v_q != 2'd2)
								v_q <= v_q + 1'b1;
							else
								state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_NEXT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer && (item.data.opcode == OP_CORNER)) begin
			pos_q[POS_AW'(item.data.corner_index) * POS_AW'(3)] <= item.data.pos_x;
			pos_q[POS_AW'(item.data.corner_index) * POS_AW'(3) + POS_AW'(1)] <=
				item.data.pos_y;
			pos_q[POS_AW'(item.data.corner_index) * POS_AW'(3) + POS_AW'(2)] <=
				item.data.pos_z;
			cv_q[item.data.corner_index] <= item.data.corner_weight;
		end
		case (state_q)
			S_CASE: case_q <= cs;
			S_ROW:  base_q <= TBL_AW'(row) * TBL_AW'(ROW_WORDS);
			S_W1:   w1_q <= cv_q[c1];
			S_W2: begin
				num_q <= {iso_q[31], iso_q} - {w1_q[31], w1_q};
				den_q <= {cv_q[c2][31], cv_q[c2]} - {w1_q[31], w1_q};
			end
			S_ABS: begin
				if (den_q[32]) begin
					num_q <= -num_q;
					den_q <= -den_q;
				end
			end
			S_DIV: t_q <= div_quot;
			S_P1:  p1_q <= pos_q[pa1];
			S_P2:  diff_q <= $signed({pos_q[pa2][31], pos_q[pa2]}) - $signed({p1_q[31], p1_q});
			S_MUL: prod_q <= diff_q * $signed({1'b0, t_q});
			S_TW_CAP: code_q[j_q] <= tt_rd_q;
			S_PT: begin
				if (pt_phase_q)
					pt_q[pt_idx] <= (cur_code < 4'(EDGE_COUNT)) ? ep_rd_q : 32'd0;
			end
			S_NEXT: begin
				if (found_q == '0 && out_free)
					out_q <= '{default: '0, last_triangle: 1'b1};
			end
			S_EMIT: begin
				if (out_free) begin
					out_q.a_x <= pt_q[0];
					out_q.a_y <= pt_q[1];
					out_q.a_z <= pt_q[2];
					out_q.b_x <= pt_q[3];
					out_q.b_y <= pt_q[4];
					out_q.b_z <= pt_q[5];
					out_q.c_x <= pt_q[6];
					out_q.c_y <= pt_q[7];
					out_q.c_z <= pt_q[8];
					out_q.has_triangle  <= 1'b1;
					out_q.last_triangle <= !more_tris;
				end
			end
			default: ;
		endcase
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
endmodule

FILE: rtl/mc_div.sv
// Radix-2 restoring divider producing t = floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per cycle. Depends on mc_pkg.
module mc_div import mc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        num,
	input  logic [31:0]        den,
	output logic               busy,
	output logic [FRAC_BITS:0] quot
);
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [FRAC_BITS:0] quot_q;
	logic [32:0]      rem2;
	logic [32:0]      diff;
	logic             ge;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			// integer bit is set only when num equals den
			rem_q  <= (num == den) ? 32'd0 : num;
			quot_q <= (FRAC_BITS+1)'(num == den);
		end else if (busy_q) begin
			rem_q  <= ge ? diff[31:0] : rem2[31:0];
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule

FILE: rtl/mc_chk.sv
// Port-level checker for the marching-cubes cell, bound to the top level.
// Depends on mc_pkg for opcode names.
module mc_chk import mc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input logic [1:0] item_opcode,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res_data
);
	// a compute keeps the block busy on the following cycle
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_opcode == OP_COMPUTE |=> !item_ready)
		else $error("item taken right after a compute transfer");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.has_triangle |-> res_data.last_triangle)
		else $error("empty result not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.has_triangle |->
		res_data.a_x == 0 && res_data.b_y == 0 && res_data.c_z == 0)
		else $error("empty result carries points");
endmodule

bind marching_cubes_cell_top mc_chk u_mc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_opcode (item.data.opcode),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_data    (result.data)
);

FILE: bench/marching_cubes_cell_top_test.sv
// Self-checking bench for marching_cubes_cell_top: directed stimulus table, then random
// load/compute traffic under several idle/stall mixes, checked against a local cell predictor.
// Depends on mc_pkg and the channel interfaces in mc_if.sv.
module marching_cubes_cell_top_test;
	import mc_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int SETTLE = 800;
	localparam int IN_W = $bits(in_item_t);

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	mc_in_if  item_ch ();
	mc_out_if tri_ch ();
	mc_cfg_if cfg_ch ();

	marching_cubes_cell_top uut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(tri_ch), .cfg(cfg_ch)
	);

	// local copy of the cell state
	logic signed [31:0] iso_q;
	logic               resolve_q;
	logic signed [31:0] pos_q [POS_DEPTH];
	logic signed [31:0] weight_q [CORNER_COUNT];
	logic [3:0]         tri_words [TABLE_DEPTH];
	logic               ambig_q [256];

	out_item_t tri_queue [$];
	int        errors = 0;
	int        computes = 0;
	int        triangles = 0;
	int        src_idle = 0;
	int        sink_stall = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("marching_cubes_cell_top: mismatch");
		$finish;
	end

	function automatic logic [2:0] end_a(input int e);
		logic [2:0] a [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 3, 2};
		return a[e];
	endfunction

	function automatic logic [2:0] end_b(input int e);
		logic [2:0] b [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 7, 6};
		return b[e];
	endfunction

	// only corners 0 and 1 can rise above iso, so cases 0..3 and their mirrors are reachable
	function automatic int used_row(input int r);
		return (r < 4) ? r : 248 + r;
	endfunction

	// case number, edge interpolation, row choice and triangle emit
	function automatic void predict_triangles();
		logic [7:0]         cs;
		logic [7:0]         row;
		logic signed [31:0] pts [36];
		longint             num, den, t, p1, p2;
		int                 base, found;
		out_item_t          r;
		logic [3:0]         code;
		cs = '0;
		found = 0;
		for (int i = 0; i < CORNER_COUNT; i++)
			if (weight_q[i] > iso_q) cs[i] = 1'b1;
		for (int e = 0; e < EDGE_COUNT; e++) begin
			for (int ax = 0; ax < 3; ax++) pts[e*3+ax] = '0;
			num = longint'(iso_q) - longint'(weight_q[end_a(e)]);
			den = longint'(weight_q[end_b(e)]) - longint'(weight_q[end_a(e)]);
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (den != 0 && num >= 0 && num <= den) begin
				t = (num <<< FRAC) / den;
				for (int ax = 0; ax < 3; ax++) begin
					p1 = longint'(pos_q[end_a(e)*3+ax]);
					p2 = longint'(pos_q[end_b(e)*3+ax]);
					pts[e*3+ax] = 32'(p1 + (((p2 - p1) * t) >>> FRAC));
				end
			end
		end
		row = (ambig_q[cs] && !resolve_q) ? CASE_MAX - cs : cs;
		base = int'(row) * ROW_WORDS;
		for (int k = 0; k < MAX_TRIS_DEF; k++) begin
			if (tri_words[base+3*k] == NO_TRI) continue;
			r = '0;
			code = tri_words[base+3*k];
			if (code < 12) {r.a_x, r.a_y, r.a_z} = {pts[code*3], pts[code*3+1], pts[code*3+2]};
			code = tri_words[base+3*k+1];
			if (code < 12) {r.b_x, r.b_y, r.b_z} = {pts[code*3], pts[code*3+1], pts[code*3+2]};
			code = tri_words[base+3*k+2];
			if (code < 12) {r.c_x, r.c_y, r.c_z} = {pts[code*3], pts[code*3+1], pts[code*3+2]};
			r.has_triangle = 1'b1;
			tri_queue.push_back(r);
			found++;
		end
		if (found == 0) begin
			r = '0;
			r.last_triangle = 1'b1;
			tri_queue.push_back(r);
		end else begin
			tri_queue[$].last_triangle = 1'b1;
		end
	endfunction

	function automatic void absorb_load(input in_item_t it);
		case (op_t'(it.opcode))
			OP_CORNER: begin
				pos_q[it.corner_index*3]   = it.pos_x;
				pos_q[it.corner_index*3+1] = it.pos_y;
				pos_q[it.corner_index*3+2] = it.pos_z;
				weight_q[it.corner_index]  = it.corner_weight;
			end
			OP_TABLE: if (it.table_address < TABLE_DEPTH) tri_words[it.table_address] = it.table_word;
			OP_AMBIG: ambig_q[it.case_select] = it.ambiguous_bit;
			default: ;
		endcase
	endfunction

	task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
		while ($urandom_range(99) < src_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
		if (op_t'(it.opcode) == OP_COMPUTE) begin
			computes++;
			if (typed) tri_queue.push_back(want);
			else predict_triangles();
		end else begin
			absorb_load(it);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.value <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_ISO) iso_q = val;
		else resolve_q = val[0];
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (tri_queue.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic in_item_t noise_item(input op_t op);
		in_item_t it;
		it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.opcode = op;
		return it;
	endfunction

	function automatic logic [3:0] rand_code();
		int r;
		r = $urandom_range(99);
		if (r < 40) return NO_TRI;
		if (r < 47) return 4'($urandom_range(14, 12));
		return 4'($urandom_range(11));
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			it = noise_item(OP_COMPUTE);
		end else if (r < 60) begin
			it = noise_item(OP_CORNER);
			// mostly near the iso level so edges actually cross
			if ($urandom_range(3) != 0)
				it.corner_weight = iso_q + $signed(32'($urandom_range(2_000_000))) - 1_000_000;
			// corners 2..7 never rise above iso, keeping the case inside the loaded rows
			if (it.corner_index > 3'd1)
				it.corner_weight = 32'h8000_0000;
			if ($urandom_range(1)) begin
				it.pos_x = $signed(32'($urandom_range(20_000_000))) - 10_000_000;
				it.pos_y = $signed(32'($urandom_range(20_000_000))) - 10_000_000;
				it.pos_z = $signed(32'($urandom_range(20_000_000))) - 10_000_000;
			end
		end else if (r < 88) begin
			it = noise_item(OP_TABLE);
			if ($urandom_range(9) != 0)
				it.table_address = 12'(used_row($urandom_range(7)) * ROW_WORDS +
					$urandom_range(ROW_WORDS - 1));
			it.table_word = rand_code();
		end else begin
			it = noise_item(OP_AMBIG);
		end
		return it;
	endfunction

	// result side: stall at random, compare each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r, got;
		if (!arst_n) begin
			tri_ch.ready <= 1'b0;
		end else begin
			if (tri_ch.valid && tri_ch.ready) begin
				got = tri_ch.data;
				if (tri_queue.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					exp_r = tri_queue.pop_front();
					if (got.has_triangle) triangles++;
					if (got.a_x !== exp_r.a_x) begin $error("a_x exp %0d got %0d", exp_r.a_x, got.a_x); errors++; end
					if (got.a_y !== exp_r.a_y) begin $error("a_y exp %0d got %0d", exp_r.a_y, got.a_y); errors++; end
					if (got.a_z !== exp_r.a_z) begin $error("a_z exp %0d got %0d", exp_r.a_z, got.a_z); errors++; end
					if (got.b_x !== exp_r.b_x) begin $error("b_x exp %0d got %0d", exp_r.b_x, got.b_x); errors++; end
					if (got.b_y !== exp_r.b_y) begin $error("b_y exp %0d got %0d", exp_r.b_y, got.b_y); errors++; end
					if (got.b_z !== exp_r.b_z) begin $error("b_z exp %0d got %0d", exp_r.b_z, got.b_z); errors++; end
					if (got.c_x !== exp_r.c_x) begin $error("c_x exp %0d got %0d", exp_r.c_x, got.c_x); errors++; end
					if (got.c_y !== exp_r.c_y) begin $error("c_y exp %0d got %0d", exp_r.c_y, got.c_y); errors++; end
					if (got.c_z !== exp_r.c_z) begin $error("c_z exp %0d got %0d", exp_r.c_z, got.c_z); errors++; end
					if (got.has_triangle !== exp_r.has_triangle) begin
						$error("has_triangle exp %0b got %0b", exp_r.has_triangle, got.has_triangle);
						errors++;
					end
					if (got.last_triangle !== exp_r.last_triangle) begin
						$error("last_triangle exp %0b got %0b", exp_r.last_triangle, got.last_triangle);
						errors++;
					end
				end
			end
			tri_ch.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	initial begin
		dir_row_t  rows [$];
		dir_row_t  row;
		in_item_t  it;
		out_item_t none_r;
		int        idle_mix [4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{34, 34}};
		logic [31:0] iso_set [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0};

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ISO;
		cfg_ch.value = '0;
		iso_q = '0;
		resolve_q = 1'b0;
		foreach (ambig_q[i]) ambig_q[i] = 1'b0;
		none_r = '0;
		none_r.last_triangle = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_ISO, 32'h0);
		write_reg(REG_RESOLVE, 1'b0);

		// every reachable table row first, so no compute reads an unwritten word
		for (int r = 0; r < 8; r++) begin
			for (int w = 0; w < ROW_WORDS; w++) begin
				it = noise_item(OP_TABLE);
				it.table_address = 12'(used_row(r) * ROW_WORDS + w);
				it.table_word = rand_code();
				push_item(it, 1'b0, none_r);
			end
		end

		// directed: extreme corners all below iso, empty row 0, ambiguity, bad codes
		for (int c = 0; c < CORNER_COUNT; c++) begin
			row.it = noise_item(OP_CORNER);
			row.it.corner_index = 3'(c);
			row.it.pos_x = c[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			row.it.pos_y = c[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
			row.it.pos_z = c[2] ? 32'h0 : 32'hFFFF_FFFF;
			row.it.corner_weight = 32'h8000_0000;
			row.typed = 1'b0;
			rows.push_back(row);
		end
		for (int k = 0; k < MAX_TRIS_DEF; k++) begin
			row.it = noise_item(OP_TABLE);
			row.it.table_address = 12'(3 * k);
			row.it.table_word = NO_TRI;
			rows.push_back(row);
		end
		row.it = noise_item(OP_COMPUTE);
		row.typed = 1'b1;
		row.want = none_r;
		rows.push_back(row);
		row.typed = 1'b0;
		row.it = noise_item(OP_TABLE);
		row.it.table_address = 12'hFFF;    // out of range, dropped
		row.it.table_word = 4'd0;
		rows.push_back(row);
		row.it = noise_item(OP_AMBIG);
		row.it.case_select = 8'd0;
		row.it.ambiguous_bit = 1'b1;
		rows.push_back(row);
		row.it = noise_item(OP_COMPUTE);
		rows.push_back(row);
		row.it = noise_item(OP_CORNER);
		row.it.corner_index = 3'd0;
		row.it.pos_x = 32'h0001_0000;
		row.it.corner_weight = 32'h7FFF_FFFF;
		rows.push_back(row);
		row.it = noise_item(OP_TABLE);
		row.it.table_address = 12'd15;
		row.it.table_word = 4'd12;         // bad edge code
		rows.push_back(row);
		row.it = noise_item(OP_TABLE);
		row.it.table_address = 12'd16;
		row.it.table_word = 4'd0;
		rows.push_back(row);
		row.it = noise_item(OP_COMPUTE);
		rows.push_back(row);
		row.it = noise_item(OP_AMBIG);
		row.it.case_select = 8'd0;
		row.it.ambiguous_bit = 1'b0;
		rows.push_back(row);

		foreach (rows[i]) push_item(rows[i].it, rows[i].typed, rows[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			src_idle = idle_mix[ph][0];
			sink_stall = idle_mix[ph][1];
			write_reg(REG_ISO, (ph == 3) ? $urandom : iso_set[ph]);
			write_reg(REG_RESOLVE, ph[0]);
			for (int n = 0; n < 25; n++) push_item(rand_item(), 1'b0, none_r);
		end
		drain();

		$display("covered %0d computes, %0d triangles, 4 idle/stall mixes, iso extremes",
			computes, triangles);
		$display("resolve mode on and off, reachable table rows plus random corner/table/flag loads");
		if (errors == 0 && tri_queue.size() == 0)
			$display("marching_cubes_cell_top: match");
		else
			$display("marching_cubes_cell_top: mismatch");
		$finish;
	end

endmodule
